@@ rtl/mfdr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and handshake structs for the mesh flood relay.
// Used by the seen cache, the payload buffer and the top level.
package mfdr_pkg;

  localparam int SeenDepthDef  = 16;
  localparam int MaxPayloadDef = 13;
  localparam int HdrLen        = 6;

  localparam logic [7:0]  MAGIC_BYTE = 8'h4D;
  localparam logic [31:0] EMPTY_KEY  = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_RELAY   = 2'd2;

  localparam logic [1:0] V_DELIVERED = 2'd0;
  localparam logic [1:0] V_NOT_MESH  = 2'd1;
  localparam logic [1:0] V_ECHO      = 2'd2;
  localparam logic [1:0] V_DUPLICATE = 2'd3;

  localparam logic REG_RELAY_EN = 1'b0;
  localparam logic REG_OWN_ID   = 1'b1;

  typedef struct packed {
    logic start;
    logic commit;
  } seen_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } seen_rsp_t;

endpackage

@@ rtl/mfdr_seen_cache.sv @@
`timescale 1ns / 1ps
// Ring of recently seen packet keys in a synchronous one-read-port memory.
// Searches the ring one entry per cycle and records new keys. Uses mfdr_pkg.
module mfdr_seen_cache #(
  parameter int SEEN_DEPTH = mfdr_pkg::SeenDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfdr_pkg::seen_req_t req_i,
  input  logic [31:0]         key_i,
  output mfdr_pkg::seen_rsp_t rsp_o
);
  import mfdr_pkg::*;

  localparam int IW = $clog2(SEEN_DEPTH);
  localparam int CW = $clog2(SEEN_DEPTH + 1);

  logic [31:0]   mem [SEEN_DEPTH];
  logic [31:0]   rdata_q;
  logic          scan_q, scan_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          cmp_v_q, cmp_last_q;
  logic [IW-1:0] cmp_idx_q;
  logic          hit_q, hit_d;
  logic [IW-1:0] next_q, next_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [31:0]   entry;
  logic          match;
  logic          rd_last;

  // Entries at or beyond the fill count were never written and read as empty.
  assign entry   = (CW'(cmp_idx_q) < fill_q) ? rdata_q : EMPTY_KEY;
  assign match   = cmp_v_q && (entry == key_i);
  assign rd_last = (rd_idx_q == IW'(SEEN_DEPTH - 1));

  assign rsp_o.done = cmp_v_q && cmp_last_q;
  assign rsp_o.hit  = hit_q || match;

  always_comb begin
    scan_d   = scan_q;
    rd_idx_d = rd_idx_q;
    hit_d    = hit_q || match;
    next_d   = next_q;
    fill_d   = fill_q;
    if (req_i.start) begin
      scan_d   = 1'b1;
      rd_idx_d = '0;
      hit_d    = 1'b0;
    end else if (scan_q) begin
      rd_idx_d = rd_idx_q + IW'(1);
      if (rd_last) begin
        scan_d = 1'b0;
      end
    end
    if (req_i.commit) begin
      next_d = (next_q == IW'(SEEN_DEPTH - 1)) ? '0 : next_q + IW'(1);
      if (fill_q != CW'(SEEN_DEPTH)) begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= 1'b0;
      rd_idx_q   <= '0;
      cmp_v_q    <= 1'b0;
      cmp_last_q <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      next_q     <= '0;
      fill_q     <= '0;
    end else begin
      scan_q     <= scan_d;
      rd_idx_q   <= rd_idx_d;
      cmp_v_q    <= scan_q && !req_i.start;
      cmp_last_q <= scan_q && rd_last;
      cmp_idx_q  <= rd_idx_q;
      hit_q      <= hit_d;
      next_q     <= next_d;
      fill_q     <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.commit) begin
      mem[next_q] <= key_i;
    end
    if (scan_q) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

endmodule

@@ rtl/mfdr_pay_buf.sv @@
`timescale 1ns / 1ps
// Payload byte buffer: one write port and one registered read port.
// Depends on mfdr_pkg for the default depth.
module mfdr_pay_buf #(
  parameter int MAX_PAYLOAD = mfdr_pkg::MaxPayloadDef,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

endmodule

@@ rtl/mesh_flood_dedup_relay_top.sv @@
`timescale 1ns / 1ps
// Mesh flood relay: receives a packet one byte per beat, checks it against a
// ring of recently seen keys, and streams the verdict, payload and relay bytes.
// Depends on mfdr_pkg, mfdr_seen_cache and mfdr_pay_buf.
//
// Each received byte is taken in ST_RX. After the last byte the block checks the
// header in ST_CHK; a packet that is neither malformed nor an echo is then
// searched against the seen ring, one entry per cycle through the ring
// memory's single read port. The verdict goes straight to the output register,
// while every payload or relay byte passes through ST_RD, where payload bytes
// are read from the payload buffer, and ST_WR, which loads the output register.
// The ring needs no clearing pass after reset: a fill count marks the entries
// written so far, and the others read as empty.
module mesh_flood_dedup_relay_top #(
  parameter int SEEN_DEPTH  = mfdr_pkg::SeenDepthDef,
  parameter int MAX_PAYLOAD = mfdr_pkg::MaxPayloadDef,
  parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             rx_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [1:0]       verdict_o,
  output logic             relay_flag_o,
  output logic [7:0]       hop_ttl_o,
  output logic [15:0]      message_id_o,
  output logic [15:0]      source_id_o,
  output logic [CNT_W-1:0] payload_count_o,
  output logic [7:0]       data_byte_o,
  output logic             out_last_o
);
  import mfdr_pkg::*;

  localparam int POS_W = $clog2(HdrLen + MAX_PAYLOAD + 1);
  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [2:0] ST_RX   = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_VERD = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic             relay_en_q;
  logic [15:0]      own_id_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             magic_q, magic_d;
  logic [7:0]       ttl_q, ttl_d;
  logic [15:0]      msg_q, msg_d;
  logic [15:0]      src_q, src_d;
  logic [1:0]       vcode_q, vcode_d;
  logic             relay_q, relay_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             phase_q, phase_d;
  logic [POS_W-1:0] idx_q, idx_d;

  logic             o_valid_q, o_valid_d;
  logic [1:0]       o_kind_q, o_kind_d;
  logic [1:0]       o_verd_q, o_verd_d;
  logic             o_relay_q, o_relay_d;
  logic [7:0]       o_ttl_q, o_ttl_d;
  logic [15:0]      o_msg_q, o_msg_d;
  logic [15:0]      o_src_q, o_src_d;
  logic [CNT_W-1:0] o_cnt_q, o_cnt_d;
  logic [7:0]       o_data_q, o_data_d;
  logic             o_last_q, o_last_d;

  seen_req_t        seen_req;
  seen_rsp_t        seen_rsp;
  logic             in_acc;
  logic             ofree;
  logic             load;
  logic [POS_W-1:0] pay_off;
  logic [POS_W-1:0] rd_off;
  logic [POS_W-1:0] idx_nx;
  logic             pay_we;
  logic             pay_re;
  logic [7:0]       pay_rdata;
  logic [7:0]       hdr_byte;
  logic             is_delivered;

  assign in_stall_o   = (state_q != ST_RX);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign ofree        = !o_valid_q || !out_stall_i;
  assign pay_off      = pos_q - POS_W'(HdrLen);
  assign pay_we       = in_acc && (pos_q >= POS_W'(HdrLen))
                        && (pos_q < POS_W'(HdrLen + MAX_PAYLOAD));
  assign rd_off       = phase_q ? (idx_q - POS_W'(HdrLen)) : idx_q;
  assign pay_re       = (state_q == ST_RD) && (!phase_q || (idx_q >= POS_W'(HdrLen)));
  assign idx_nx       = idx_q + POS_W'(1);
  assign is_delivered = (vcode_q == V_DELIVERED);

  always_comb begin
    unique case (idx_q[2:0])
      3'd0:    hdr_byte = MAGIC_BYTE;
      3'd1:    hdr_byte = ttl_q - 8'd1;
      3'd2:    hdr_byte = msg_q[7:0];
      3'd3:    hdr_byte = msg_q[15:8];
      3'd4:    hdr_byte = src_q[7:0];
      3'd5:    hdr_byte = src_q[15:8];
      default: hdr_byte = 8'd0;
    endcase
  end

  mfdr_seen_cache #(
    .SEEN_DEPTH(SEEN_DEPTH)
  ) u_seen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (seen_req),
    .key_i ({msg_q, src_q}),
    .rsp_o (seen_rsp)
  );

  mfdr_pay_buf #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW         (AW)
  ) u_pay (
    .clk_i    (clk_i),
    .wr_en_i  (pay_we),
    .wr_addr_i(pay_off[AW-1:0]),
    .wr_data_i(rx_byte_i),
    .rd_en_i  (pay_re),
    .rd_addr_i(rd_off[AW-1:0]),
    .rd_data_o(pay_rdata)
  );

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    magic_d  = magic_q;
    ttl_d    = ttl_q;
    msg_d    = msg_q;
    src_d    = src_q;
    vcode_d  = vcode_q;
    relay_d  = relay_q;
    count_d  = count_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    seen_req = '0;
    load     = 1'b0;
    o_kind_d = KIND_VERDICT;
    o_data_d = 8'd0;
    o_last_d = 1'b1;

    unique case (state_q)
      ST_RX: begin
        if (in_acc) begin
          unique case (pos_q)
            POS_W'(0): magic_d = (rx_byte_i == MAGIC_BYTE);
            POS_W'(1): ttl_d = rx_byte_i;
            POS_W'(2): msg_d = {msg_q[15:8], rx_byte_i};
            POS_W'(3): msg_d = {rx_byte_i, msg_q[7:0]};
            POS_W'(4): src_d = {src_q[15:8], rx_byte_i};
            POS_W'(5): src_d = {rx_byte_i, src_q[7:0]};
            default: ;
          endcase
          if (pos_q < POS_W'(HdrLen + MAX_PAYLOAD)) begin
            pos_d = pos_q + POS_W'(1);
          end
          if (rx_last_i) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        pos_d   = '0;
        magic_d = 1'b0;
        relay_d = 1'b0;
        count_d = '0;
        if ((pos_q < POS_W'(HdrLen)) || !magic_q) begin
          vcode_d = V_NOT_MESH;
          state_d = ST_VERD;
        end else begin
          count_d = CNT_W'(pay_off);
          if (src_q == own_id_q) begin
            vcode_d = V_ECHO;
            state_d = ST_VERD;
          end else begin
            seen_req.start = 1'b1;
            state_d        = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (seen_rsp.done) begin
          state_d = ST_VERD;
          if (seen_rsp.hit) begin
            vcode_d = V_DUPLICATE;
          end else begin
            vcode_d         = V_DELIVERED;
            relay_d         = relay_en_q && (ttl_q != 8'd0);
            seen_req.commit = 1'b1;
          end
        end
      end
      ST_VERD: begin
        if (ofree) begin
          load     = 1'b1;
          o_last_d = !(is_delivered && (relay_q || (count_q != '0)));
          idx_d    = '0;
          phase_d  = (count_q == '0);
          state_d  = o_last_d ? ST_RX : ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (ofree) begin
          load = 1'b1;
          if (!phase_q) begin
            o_kind_d = KIND_PAYLOAD;
            o_data_d = pay_rdata;
            o_last_d = !relay_q && (idx_nx == POS_W'(count_q));
            if (idx_nx == POS_W'(count_q)) begin
              phase_d = 1'b1;
              idx_d   = '0;
              state_d = relay_q ? ST_RD : ST_RX;
            end else begin
              idx_d   = idx_nx;
              state_d = ST_RD;
            end
          end else begin
            o_kind_d = KIND_RELAY;
            o_data_d = (idx_q < POS_W'(HdrLen)) ? hdr_byte : pay_rdata;
            o_last_d = (idx_nx == POS_W'(HdrLen) + POS_W'(count_q));
            idx_d    = idx_nx;
            state_d  = o_last_d ? ST_RX : ST_RD;
          end
        end
      end
      default: state_d = ST_RX;
    endcase
  end

  // Malformed packets report a blank header and no payload.
  always_comb begin
    o_valid_d = o_valid_q && out_stall_i;
    o_verd_d  = o_verd_q;
    o_relay_d = o_relay_q;
    o_ttl_d   = o_ttl_q;
    o_msg_d   = o_msg_q;
    o_src_d   = o_src_q;
    o_cnt_d   = o_cnt_q;
    if (load) begin
      o_valid_d = 1'b1;
      o_verd_d  = vcode_q;
      o_relay_d = relay_q;
      o_cnt_d   = count_q;
      o_ttl_d   = (vcode_q == V_NOT_MESH) ? 8'd0 : ttl_q;
      o_msg_d   = (vcode_q == V_NOT_MESH) ? 16'd0 : msg_q;
      o_src_d   = (vcode_q == V_NOT_MESH) ? 16'd0 : src_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RX;
      relay_en_q <= 1'b1;
      own_id_q   <= '0;
      pos_q      <= '0;
      magic_q    <= 1'b0;
      ttl_q      <= '0;
      msg_q      <= '0;
      src_q      <= '0;
      vcode_q    <= V_DELIVERED;
      relay_q    <= 1'b0;
      count_q    <= '0;
      phase_q    <= 1'b0;
      idx_q      <= '0;
      o_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      magic_q   <= magic_d;
      ttl_q     <= ttl_d;
      msg_q     <= msg_d;
      src_q     <= src_d;
      vcode_q   <= vcode_d;
      relay_q   <= relay_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      o_valid_q <= o_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RELAY_EN: relay_en_q <= cfg_data_i[0];
          REG_OWN_ID:   own_id_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_kind_q <= o_kind_d;
      o_data_q <= o_data_d;
      o_last_q <= o_last_d;
    end
    o_verd_q  <= o_verd_d;
    o_relay_q <= o_relay_d;
    o_ttl_q   <= o_ttl_d;
    o_msg_q   <= o_msg_d;
    o_src_q   <= o_src_d;
    o_cnt_q   <= o_cnt_d;
  end

  assign out_valid_o     = o_valid_q;
  assign out_kind_o      = o_kind_q;
  assign verdict_o       = o_verd_q;
  assign relay_flag_o    = o_relay_q;
  assign hop_ttl_o       = o_ttl_q;
  assign message_id_o    = o_msg_q;
  assign source_id_o     = o_src_q;
  assign payload_count_o = o_cnt_q;
  assign data_byte_o     = o_data_q;
  assign out_last_o      = o_last_q;

`ifndef SYNTH
  a_data_beat_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != KIND_VERDICT) |-> verdict_o == V_DELIVERED)
    else $error("payload or relay beat carries a verdict other than delivered");

  a_not_mesh_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == V_NOT_MESH)
    |-> (message_id_o == 16'd0) && (source_id_o == 16'd0) && out_last_o)
    else $error("malformed packet verdict carries header data");

  a_relay_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_RELAY) |-> relay_flag_o)
    else $error("relay beat without relay flag");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> payload_count_o <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count above maximum");
`endif

endmodule

@@ verif/mesh_flood_dedup_relay_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for mesh_flood_dedup_relay_top: drives received packets beat by beat,
// predicts verdict, payload and relay beats from its own model of the node, compares them.
// Depends on mfdr_pkg and the relay RTL only.
module mesh_flood_dedup_relay_top_tb;
  import mfdr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  verdict;
    logic        relay;
    logic [7:0]  ttl;
    logic [15:0] msg;
    logic [15:0] src;
    logic [3:0]  count;
    logic [7:0]  data;
    logic        last;
  } node_out_t;

  typedef struct {
    logic [7:0]  magic;
    logic [7:0]  ttl;
    logic [15:0] msg;
    logic [15:0] src;
    int unsigned len;
    logic [7:0]  fill;
    bit          typed;
    logic [1:0]  verdict;
  } pkt_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        rx_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  out_kind_o;
  logic [1:0]  verdict_o;
  logic        relay_flag_o;
  logic [7:0]  hop_ttl_o;
  logic [15:0] message_id_o;
  logic [15:0] source_id_o;
  logic [3:0]  payload_count_o;
  logic [7:0]  data_byte_o;
  logic        out_last_o;

  // Predicted node state and register copies.
  logic [31:0] seen_key [SeenDepthDef];
  logic [3:0]  seen_wr;
  int unsigned rx_pos;
  bit          hdr_magic;
  logic [7:0]  hdr_ttl;
  logic [15:0] hdr_msg;
  logic [15:0] hdr_src;
  logic [7:0]  pay_mem [MaxPayloadDef];
  bit          relay_en_m;
  logic [15:0] own_id_m;

  node_out_t   node_out_q [$];
  node_out_t   got_out;
  node_out_t   due_out;
  logic [7:0]  pkt_q [$];
  logic [31:0] key_hist [$];
  int unsigned fail_cnt;
  bit          in_calm;
  bit          out_calm;

  pkt_row_t dir_rows [9] = '{
    '{8'h4D, 8'h00, 16'h0000, 16'h0000,  1, 8'h00, 1'b1, V_NOT_MESH},
    '{8'h4C, 8'h03, 16'h1111, 16'h2222,  6, 8'h00, 1'b1, V_NOT_MESH},
    '{8'h4D, 8'h05, 16'h3333, 16'h4444,  5, 8'h00, 1'b1, V_NOT_MESH},
    '{8'h4D, 8'h00, 16'h0000, 16'h0000,  6, 8'h00, 1'b1, V_ECHO},
    '{8'h4D, 8'hFF, 16'hFFFF, 16'hFFFF,  6, 8'h00, 1'b1, V_DUPLICATE},
    '{8'h4D, 8'h02, 16'h0001, 16'h0100,  7, 8'h00, 1'b0, V_DELIVERED},
    '{8'h4D, 8'h02, 16'h0001, 16'h0100,  7, 8'h00, 1'b1, V_DUPLICATE},
    '{8'h4D, 8'h00, 16'hFFFF, 16'hFFFE,  6, 8'h00, 1'b0, V_DELIVERED},
    '{8'h4D, 8'hFF, 16'h8000, 16'h7FFF, 22, 8'hF8, 1'b0, V_DELIVERED}
  };

  mesh_flood_dedup_relay_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .rx_last_i      (rx_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .verdict_o      (verdict_o),
    .relay_flag_o   (relay_flag_o),
    .hop_ttl_o      (hop_ttl_o),
    .message_id_o   (message_id_o),
    .source_id_o    (source_id_o),
    .payload_count_o(payload_count_o),
    .data_byte_o    (data_byte_o),
    .out_last_o     (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic string fmt_out(node_out_t o);
    return $sformatf("kind=%0d verdict=%0d relay=%0b ttl=%h msg=%h src=%h cnt=%0d %s",
                     o.kind, o.verdict, o.relay, o.ttl, o.msg, o.src, o.count,
                     $sformatf("data=%h last=%0b", o.data, o.last));
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void put_out(logic [1:0] kind, logic [1:0] v, logic rf, logic [3:0] cnt,
                                  logic [7:0] d, logic fin);
    node_out_t o;
    o.kind    = kind;
    o.verdict = v;
    o.relay   = rf;
    o.ttl     = (v == V_NOT_MESH) ? 8'h00 : hdr_ttl;
    o.msg     = (v == V_NOT_MESH) ? 16'h0000 : hdr_msg;
    o.src     = (v == V_NOT_MESH) ? 16'h0000 : hdr_src;
    o.count   = cnt;
    o.data    = d;
    o.last    = fin;
    node_out_q.push_back(o);
  endfunction

  // Returns the number of beats the node emits for this received byte.
  function automatic int unsigned node_take_byte(logic [7:0] b, logic l);
    int unsigned len;
    int unsigned cnt;
    int unsigned n;
    bit          relay;
    bit          hit;
    logic [7:0]  d;
    logic [31:0] key;
    case (rx_pos)
      0: hdr_magic = (b == MAGIC_BYTE);
      1: hdr_ttl = b;
      2: hdr_msg[7:0] = b;
      3: hdr_msg[15:8] = b;
      4: hdr_src[7:0] = b;
      5: hdr_src[15:8] = b;
      default: begin
        if (rx_pos < HdrLen + MaxPayloadDef) pay_mem[rx_pos - HdrLen] = b;
      end
    endcase
    if (rx_pos < HdrLen + MaxPayloadDef) rx_pos++;
    if (!l) return 0;
    len = rx_pos;
    rx_pos = 0;
    if (len < HdrLen || !hdr_magic) begin
      hdr_magic = 1'b0;
      put_out(KIND_VERDICT, V_NOT_MESH, 1'b0, 4'd0, 8'h00, 1'b1);
      return 1;
    end
    hdr_magic = 1'b0;
    cnt = len - HdrLen;
    if (hdr_src == own_id_m) begin
      put_out(KIND_VERDICT, V_ECHO, 1'b0, cnt[3:0], 8'h00, 1'b1);
      return 1;
    end
    key = {hdr_msg, hdr_src};
    hit = 1'b0;
    for (int i = 0; i < SeenDepthDef; i++) begin
      if (seen_key[i] == key) hit = 1'b1;
    end
    if (hit) begin
      put_out(KIND_VERDICT, V_DUPLICATE, 1'b0, cnt[3:0], 8'h00, 1'b1);
      return 1;
    end
    seen_key[seen_wr] = key;
    seen_wr++;
    relay = relay_en_m && (hdr_ttl != 8'h00);
    put_out(KIND_VERDICT, V_DELIVERED, relay, cnt[3:0], 8'h00, !relay && cnt == 0);
    n = 1;
    for (int i = 0; i < cnt; i++) begin
      put_out(KIND_PAYLOAD, V_DELIVERED, relay, cnt[3:0], pay_mem[i], !relay && i + 1 == cnt);
      n++;
    end
    if (relay) begin
      for (int i = 0; i < HdrLen + cnt; i++) begin
        case (i)
          0: d = MAGIC_BYTE;
          1: d = hdr_ttl - 8'd1;
          2: d = hdr_msg[7:0];
          3: d = hdr_msg[15:8];
          4: d = hdr_src[7:0];
          5: d = hdr_src[15:8];
          default: d = pay_mem[i - HdrLen];
        endcase
        put_out(KIND_RELAY, V_DELIVERED, 1'b1, cnt[3:0], d, i + 1 == HdrLen + cnt);
        n++;
      end
    end
    return n;
  endfunction

  function automatic void build_random_packet();
    int unsigned r;
    int unsigned plen;
    logic [7:0]  ttl;
    logic [15:0] msg;
    logic [15:0] src;
    pkt_q.delete();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      plen = $urandom_range(1, 8);
      for (int i = 0; i < plen; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
      if (r < 7) pkt_q[0] = MAGIC_BYTE;
      return;
    end
    r = $urandom_range(0, 99);
    ttl = (r < 15) ? 8'h00 : (r < 25) ? 8'hFF : (r < 35) ? 8'h01 : 8'($urandom_range(0, 255));
    if (key_hist.size() > 0 && $urandom_range(0, 2) == 0) begin
      {msg, src} = key_hist[$urandom_range(0, key_hist.size() - 1)];
    end else begin
      msg = 16'($urandom_range(0, 65535));
      src = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 19) == 0) {msg, src} = EMPTY_KEY;
    end
    if ($urandom_range(0, 7) == 0) src = own_id_m;
    key_hist.push_back({msg, src});
    if (key_hist.size() > 24) void'(key_hist.pop_front());
    r = $urandom_range(0, 99);
    plen = (r < 45) ? $urandom_range(0, 3) : (r < 85) ? $urandom_range(4, 13)
                                                     : $urandom_range(14, 17);
    pkt_q.push_back(MAGIC_BYTE);
    pkt_q.push_back(ttl);
    pkt_q.push_back(msg[7:0]);
    pkt_q.push_back(msg[15:8]);
    pkt_q.push_back(src[7:0]);
    pkt_q.push_back(src[15:8]);
    for (int i = 0; i < plen; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 19) == 0) begin
      r = $urandom_range(2, 5);
      while (pkt_q.size() > r) void'(pkt_q.pop_back());
    end
  endfunction

  // A typed verdict replaces the predicted one on the verdict beat of this packet.
  task automatic send_beat(logic [7:0] b, logic l, bit typed, logic [1:0] v);
    int unsigned pushed;
    int unsigned gap;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    rx_last_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
    pushed = node_take_byte(b, l);
    if (typed && pushed > 0) node_out_q[node_out_q.size() - pushed].verdict = v;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_packet(bit typed, logic [1:0] v);
    for (int i = 0; i < pkt_q.size(); i++) begin
      send_beat(pkt_q[i], i == pkt_q.size() - 1, typed, v);
    end
  endtask

  task automatic settle_node();
    in_valid_i <= 1'b0;
    while (node_out_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    if (idx == REG_RELAY_EN) relay_en_m = d[0];
    else own_id_m = d;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_out = '{out_kind_o, verdict_o, relay_flag_o, hop_ttl_o, message_id_o, source_id_o,
                  payload_count_o, data_byte_o, out_last_o};
      if (node_out_q.size() == 0) begin
        $display("%0t: unexpected beat: %s", $time, fmt_out(got_out));
        fail_cnt++;
      end else begin
        due_out = node_out_q.pop_front();
        if (got_out !== due_out) begin
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, fmt_out(due_out),
                   fmt_out(got_out));
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int unsigned n;
      n = pick_gap(out_calm);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    logic [7:0]  hb [HdrLen];
    bit          relay_set [4];
    logic [15:0] own_set [4];
    logic [15:0] d;
    int unsigned sent;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_RELAY_EN;
    cfg_data_i <= 16'h0000;
    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;
    rx_last_i  <= 1'b0;
    fail_cnt   = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    for (int i = 0; i < SeenDepthDef; i++) seen_key[i] = EMPTY_KEY;
    for (int i = 0; i < MaxPayloadDef; i++) pay_mem[i] = 8'h00;
    seen_wr    = '0;
    rx_pos     = 0;
    hdr_magic  = 1'b0;
    hdr_ttl    = '0;
    hdr_msg    = '0;
    hdr_src    = '0;
    relay_en_m = 1'b1;
    own_id_m   = 16'h0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      hb = '{dir_rows[r].magic, dir_rows[r].ttl, dir_rows[r].msg[7:0], dir_rows[r].msg[15:8],
             dir_rows[r].src[7:0], dir_rows[r].src[15:8]};
      pkt_q.delete();
      for (int i = 0; i < dir_rows[r].len; i++) begin
        pkt_q.push_back(i < HdrLen ? hb[i] : dir_rows[r].fill + 8'(i - HdrLen));
      end
      send_packet(dir_rows[r].typed, dir_rows[r].verdict);
    end
    settle_node();

    relay_set = '{1'b0, 1'b1, 1'b1, 1'b0};
    own_set   = '{16'hFFFF, 16'($urandom_range(1, 65534)), 16'hFFFF, 16'h0000};
    for (int p = 0; p < 4; p++) begin
      d = 16'($urandom_range(0, 65535));
      d[0] = relay_set[p];
      write_reg(REG_RELAY_EN, d);
      write_reg(REG_OWN_ID, own_set[p]);
      in_calm  = (p == 0);
      out_calm = (p == 1);
      sent = 0;
      while (sent < 32) begin
        build_random_packet();
        sent += pkt_q.size();
        send_packet(1'b0, V_DELIVERED);
      end
      settle_node();
    end

    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
